// ----- design/lwpi_pkg.sv -----
// Shared types, codes and sizes of the looping waypoint path interpolator.
package lwpi_pkg;

	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// request operations
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_START  = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [2:0] {
		STS_OK          = 3'd0,
		STS_NOT_RUNNING = 3'd1,
		STS_REFUSED     = 3'd2,
		STS_RUNNING     = 3'd3,
		STS_FULL        = 3'd4
	} status_t;

	// shared arithmetic unit operations
	typedef enum logic [1:0] {
		ALU_MUL  = 2'd0,
		ALU_DIV  = 2'd1,
		ALU_SQRT = 2'd2
	} alu_op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_LDA0, S_LDA1, S_LDB0, S_LDB1, S_SQ_GO, S_SQ_W, S_RT_GO, S_RT_W,
		S_DUR_GO, S_DUR_W, S_MOD_GO, S_MOD_W, S_SCAN0, S_SCAN1, S_F_GO, S_F_W,
		S_HOLD0, S_HOLD1, S_LRP_GO, S_LRP_W, S_VM_GO, S_VM_W, S_VD_GO, S_VD_W
	} state_t;

	typedef struct packed {
		logic        [1:0]  operation;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic        [31:0] dwell_time;
		logic signed [31:0] time_now;
		logic signed [31:0] time_into_lap;
	} req_t;

	typedef struct packed {
		logic        [2:0]  status;
		logic signed [31:0] place_x;
		logic signed [31:0] place_y;
		logic signed [31:0] place_z;
		logic signed [31:0] velocity_x;
		logic signed [31:0] velocity_y;
		logic signed [31:0] velocity_z;
		logic               is_moving;
	} rsp_t;

	// handshake between sequencer and arithmetic unit
	typedef struct packed {
		logic       go;
		alu_op_t    op;
		logic [63:0] a;
		logic [63:0] b;
	} alu_cmd_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] res;
		logic [63:0] rem;
	} alu_rsp_t;

endpackage

// ----- design/looping_waypoint_path_interpolator.sv -----
// Top level: waypoint tables, sequencer and result register of the path interpolator.
//
// A request is taken when start is high and busy is low; its result appears in the
// cycle after the work ends, on result for exactly one cycle with done high, and
// cannot be held off. Clear, append and every refused request finish without
// leaving the idle state. All arithmetic runs through one shared bit-serial unit
// (32 steps per multiply or square root, 64 per divide). A start does, for each
// waypoint, two table reads, three squares, a root and a divide. A query does the
// lap modulo unless the time is before the origin or the lap is zero, scans the
// timeline table and, on a move, a fraction divide, the distance, a multiply per
// axis for the lerp and, if the distance is nonzero, a multiply and a divide per
// axis for the velocity.
// The waypoint and timeline tables hold whatever was last written.
module looping_waypoint_path_interpolator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  lwpi_pkg::req_t  request,
	output logic            done,
	output lwpi_pkg::rsp_t  result,
	input  logic            cfg_we,
	input  logic [31:0]     cfg_wdata
);
	import lwpi_pkg::*;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic        [31:0] dwell;
	} pt_t;

	typedef struct packed {
		logic [31:0] de;
		logic [31:0] me;
	} tm_t;

	pt_t pt_mem [MAX_POINTS];
	tm_t tm_mem [MAX_POINTS];

	state_t state_q, state_n;

	logic [31:0]      speed_q, origin_q, lap_q, acc_q, t_q, de_q, me_q;
	logic [CNT_W-1:0] count_q;
	logic             running_q, done_q;
	req_t             req_q;
	rsp_t             rsp_q;
	logic [IDX_W-1:0] i_q, addr_q, nx;
	pt_t              pt_rd_q, pa_q, pb_q;
	tm_t              tm_rd_q;
	logic [1:0]       k_q;
	logic [65:0]      s_q;
	logic [32:0]      dist_q;
	logic [15:0]      f_q;

	alu_cmd_t cmd;
	alu_rsp_t ar;

	logic             acc_in, fin, last;
	logic [CNT_W-1:0] i_ext;
	logic [31:0]      e_in, a1, a2, pk, part, pos, vel;
	logic signed [31:0] ak, bk;
	logic [32:0]      d;
	logic [31:0]      mag;
	logic             is_query, root_hi;

	lwpi_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (ar)
	);

	function automatic logic [31:0] sat32(input logic [63:0] v);
		return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	// shared decode
	assign acc_in   = start && (state_q == S_IDLE);
	assign i_ext    = CNT_W'(i_q) + CNT_W'(1);
	assign last     = (i_ext == count_q);
	assign nx       = (i_ext < count_q) ? i_ext[IDX_W-1:0] : '0;
	assign e_in     = request.time_now - origin_q;
	assign is_query = (req_q.operation == OP_QUERY);
	assign root_hi  = (s_q[65:64] != 2'd0);

	// timeline partial sums
	assign a1 = sat32({32'd0, acc_q} + {32'd0, pa_q.dwell});
	assign a2 = sat32({32'd0, a1} + ar.res);

	// axis difference, position and velocity of the current segment
	always_comb begin
		case (k_q)
			2'd0:    begin ak = pa_q.x; bk = pb_q.x; end
			2'd1:    begin ak = pa_q.y; bk = pb_q.y; end
			default: begin ak = pa_q.z; bk = pb_q.z; end
		endcase
		d    = {bk[31], bk} - {ak[31], ak};
		pk   = ak;
		mag  = d[32] ? 32'(-d) : d[31:0];
		part = ar.res[47:16];
		pos  = d[32] ? pk - part : pk + part;
		if (d[32])
			vel = (ar.res > 64'h8000_0000) ? 32'h8000_0000 : (~ar.res[31:0]) + 32'd1;
		else
			vel = (ar.res > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : ar.res[31:0];
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc_in) begin
					case (request.operation)
						OP_START:
							if (!running_q && count_q >= CNT_W'(2) && speed_q != 32'd0)
								state_n = S_LDA0;
						OP_QUERY:
							if (running_q)
								state_n = (e_in[31] || lap_q == 32'd0) ? S_HOLD0 : S_MOD_GO;
						default: state_n = S_IDLE;
					endcase
				end
			end
			S_LDA0:   state_n = S_LDA1;
			S_LDA1:   state_n = S_LDB0;
			S_LDB0:   state_n = S_LDB1;
			S_LDB1:   state_n = S_SQ_GO;
			S_SQ_GO:  state_n = S_SQ_W;
			S_SQ_W:   if (ar.done) state_n = (k_q == 2'd2) ? S_RT_GO : S_SQ_GO;
			S_RT_GO:  state_n = S_RT_W;
			S_RT_W:   if (ar.done) state_n = is_query ? S_LRP_GO : S_DUR_GO;
			S_DUR_GO: state_n = S_DUR_W;
			S_DUR_W:  if (ar.done) state_n = last ? S_IDLE : S_LDA0;
			S_MOD_GO: state_n = S_MOD_W;
			S_MOD_W:  if (ar.done) state_n = S_SCAN0;
			S_SCAN0:  state_n = S_SCAN1;
			S_SCAN1: begin
				if (t_q < tm_rd_q.de)      state_n = S_HOLD0;
				else if (t_q < tm_rd_q.me) state_n = S_F_GO;
				else if (last)             state_n = S_HOLD0;
				else                       state_n = S_SCAN0;
			end
			S_F_GO:   state_n = S_F_W;
			S_F_W:    if (ar.done) state_n = S_LDA0;
			S_HOLD0:  state_n = S_HOLD1;
			S_HOLD1:  state_n = S_IDLE;
			S_LRP_GO: state_n = S_LRP_W;
			S_LRP_W: begin
				if (ar.done) begin
					if (dist_q != 33'd0) state_n = S_VM_GO;
					else state_n = (k_q == 2'd2) ? S_IDLE : S_LRP_GO;
				end
			end
			S_VM_GO:  state_n = S_VM_W;
			S_VM_W:   if (ar.done) state_n = S_VD_GO;
			S_VD_GO:  state_n = S_VD_W;
			S_VD_W:   if (ar.done) state_n = (k_q == 2'd2) ? S_IDLE : S_LRP_GO;
			default:  state_n = S_IDLE;
		endcase
	end

	// outputs: unit commands, busy, finish
	always_comb begin
		cmd.go = 1'b0;
		cmd.op = ALU_MUL;
		cmd.a  = {32'd0, mag};
		cmd.b  = {32'd0, mag};
		unique case (state_q)
			S_SQ_GO:  cmd.go = 1'b1;
			S_RT_GO: begin
				cmd.go = 1'b1;
				cmd.op = ALU_SQRT;
				cmd.a  = root_hi ? s_q[65:2] : s_q[63:0];
			end
			S_DUR_GO: begin
				cmd.go = 1'b1;
				cmd.op = ALU_DIV;
				cmd.a  = {15'd0, dist_q, 16'd0};
				cmd.b  = {32'd0, speed_q};
			end
			S_MOD_GO: begin
				cmd.go = 1'b1;
				cmd.op = ALU_DIV;
				cmd.a  = {32'd0, t_q};
				cmd.b  = {32'd0, lap_q};
			end
			S_F_GO: begin
				cmd.go = 1'b1;
				cmd.op = ALU_DIV;
				cmd.a  = {16'd0, t_q - de_q, 16'd0};
				cmd.b  = {32'd0, me_q - de_q};
			end
			S_LRP_GO: begin
				cmd.go = 1'b1;
				cmd.b  = {48'd0, f_q};
			end
			S_VM_GO: begin
				cmd.go = 1'b1;
				cmd.b  = {32'd0, speed_q};
			end
			S_VD_GO: begin
				cmd.go = 1'b1;
				cmd.op = ALU_DIV;
				cmd.a  = ar.res;
				cmd.b  = {31'd0, dist_q};
			end
			default: cmd.go = 1'b0;
		endcase
		busy = (state_q != S_IDLE);
		fin  = (busy || acc_in) && (state_n == S_IDLE);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			speed_q   <= '0;
			running_q <= 1'b0;
			count_q   <= '0;
			origin_q  <= '0;
			lap_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= fin;
			if (cfg_we)
				speed_q <= cfg_wdata;
			if (acc_in && !running_q) begin
				if (request.operation == OP_CLEAR)
					count_q <= '0;
				else if (request.operation == OP_APPEND && count_q < CNT_W'(MAX_POINTS))
					count_q <= count_q + CNT_W'(1);
			end
			if (state_q == S_DUR_W && ar.done && last) begin
				lap_q     <= a2;
				origin_q  <= req_q.time_now - req_q.time_into_lap;
				running_q <= 1'b1;
			end
		end
	end

	// table memories, registered reads
	always_ff @(posedge clk) begin
		if (acc_in && !running_q && request.operation == OP_APPEND
			&& count_q < CNT_W'(MAX_POINTS))
			pt_mem[count_q[IDX_W-1:0]] <= {request.point_x, request.point_y,
				request.point_z, request.dwell_time};
		if (state_q == S_DUR_W && ar.done)
			tm_mem[i_q] <= {a1, a2};
		pt_rd_q <= pt_mem[addr_q];
		tm_rd_q <= tm_mem[addr_q];
	end

	// datapath and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (acc_in) begin
					req_q  <= request;
					rsp_q  <= '0;
					i_q    <= '0;
					addr_q <= '0;
					acc_q  <= '0;
					t_q    <= e_in;
					case (request.operation)
						OP_APPEND:
							if (running_q) rsp_q.status <= STS_RUNNING;
							else if (count_q >= CNT_W'(MAX_POINTS)) rsp_q.status <= STS_FULL;
						OP_START:
							if (running_q) rsp_q.status <= STS_RUNNING;
							else if (count_q < CNT_W'(2) || speed_q == 32'd0)
								rsp_q.status <= STS_REFUSED;
						OP_QUERY:
							if (!running_q) rsp_q.status <= STS_NOT_RUNNING;
						default:
							if (running_q) rsp_q.status <= STS_RUNNING;
					endcase
				end
			end
			S_LDA1: begin
				pa_q   <= pt_rd_q;
				addr_q <= nx;
			end
			S_LDB1: begin
				pb_q <= pt_rd_q;
				k_q  <= 2'd0;
				s_q  <= '0;
			end
			S_SQ_W: begin
				if (ar.done) begin
					s_q <= s_q + {2'd0, ar.res};
					k_q <= k_q + 2'd1;
				end
			end
			S_RT_W: begin
				if (ar.done) begin
					dist_q <= root_hi ? {ar.res[31:0], 1'b0} : {1'b0, ar.res[31:0]};
					k_q    <= 2'd0;
				end
			end
			S_DUR_W: begin
				if (ar.done) begin
					acc_q  <= a2;
					i_q    <= nx;
					addr_q <= nx;
				end
			end
			S_MOD_W: if (ar.done) t_q <= ar.rem[31:0];
			S_SCAN1: begin
				de_q <= tm_rd_q.de;
				me_q <= tm_rd_q.me;
				if (!(t_q < tm_rd_q.me)) begin
					i_q    <= nx;
					addr_q <= nx;
				end
			end
			S_F_W:   if (ar.done) f_q <= ar.res[15:0];
			S_HOLD1: begin
				rsp_q.place_x <= pt_rd_q.x;
				rsp_q.place_y <= pt_rd_q.y;
				rsp_q.place_z <= pt_rd_q.z;
			end
			S_LRP_W: begin
				if (ar.done) begin
					rsp_q.is_moving <= 1'b1;
					case (k_q)
						2'd0:    rsp_q.place_x <= pos;
						2'd1:    rsp_q.place_y <= pos;
						default: rsp_q.place_z <= pos;
					endcase
					if (dist_q == 33'd0) k_q <= k_q + 2'd1;
				end
			end
			S_VD_W: begin
				if (ar.done) begin
					case (k_q)
						2'd0:    rsp_q.velocity_x <= vel;
						2'd1:    rsp_q.velocity_y <= vel;
						default: rsp_q.velocity_z <= vel;
					endcase
					k_q <= k_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = rsp_q;

	// checks
	a_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> !ar.busy)
		else $error("arithmetic unit launched while busy");

	a_run_holds: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |=> running_q)
		else $error("run flag dropped");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond table");

	a_idle_query: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && request.operation == OP_QUERY && !running_q)
		|=> (done && result.status == STS_NOT_RUNNING))
		else $error("query while stopped not answered at once");

endmodule

// ----- design/lwpi_unit.sv -----
// Shared bit-serial arithmetic unit: multiply, divide with remainder, square root.
module lwpi_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  lwpi_pkg::alu_cmd_t  cmd,
	output lwpi_pkg::alu_rsp_t  rsp
);
	import lwpi_pkg::*;

	alu_op_t     op_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] acc_q, x_q, y_q;
	logic [64:0] r_q;

	logic [63:0] acc_n, x_n, y_n, rb;
	logic [64:0] r_n, sh;
	logic        ge;

	// one step of the selected operation
	always_comb begin
		acc_n = acc_q;
		x_n   = x_q;
		y_n   = y_q;
		r_n   = r_q;
		sh    = {r_q[63:0], y_q[63]};
		rb    = y_q + x_q;
		ge    = 1'b0;
		unique case (op_q)
			ALU_MUL: begin
				acc_n = acc_q + (y_q[0] ? x_q : 64'd0);
				x_n   = x_q << 1;
				y_n   = y_q >> 1;
			end
			ALU_DIV: begin
				ge  = sh >= {1'b0, x_q};
				r_n = ge ? sh - {1'b0, x_q} : sh;
				y_n = {y_q[62:0], ge};
			end
			ALU_SQRT: begin
				ge    = acc_q >= rb;
				acc_n = ge ? acc_q - rb : acc_q;
				y_n   = ge ? (y_q >> 1) + x_q : y_q >> 1;
				x_n   = x_q >> 2;
			end
			default: begin
				acc_n = acc_q;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.go) begin
				busy_q <= 1'b1;
				cnt_q  <= (cmd.op == ALU_DIV) ? 7'd64 : 7'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands and partial results
	always_ff @(posedge clk) begin
		if (cmd.go) begin
			op_q <= cmd.op;
			r_q  <= '0;
			unique case (cmd.op)
				ALU_MUL: begin
					acc_q <= '0;
					x_q   <= cmd.a;
					y_q   <= {32'd0, cmd.b[31:0]};
				end
				ALU_DIV: begin
					x_q <= cmd.b;
					y_q <= cmd.a;
				end
				default: begin
					acc_q <= cmd.a;
					y_q   <= '0;
					x_q   <= 64'd1 << 62;
				end
			endcase
		end else if (busy_q) begin
			acc_q <= acc_n;
			x_q   <= x_n;
			y_q   <= y_n;
			r_q   <= r_n;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.res  = (op_q == ALU_MUL) ? acc_q : y_q;
	assign rsp.rem  = r_q[63:0];

endmodule
